[rtl/ultrasonic_echo_ranger_defines.svh]
// Assertion macros shared by the ranger's checker.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define UER_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define UER_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/uer_pkg.sv]
// Shared types, constants and helpers for the ultrasonic echo ranger.
package uer_pkg;

    // Tick counter width; counters saturate at all ones
    localparam int CNT_W      = 20;
    localparam int DIST_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int TRIG_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W     = CNT_W + SCALE_W;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INTERVAL    = 3'd0,
        REG_TRIG_WIDTH  = 3'd1,
        REG_START_TO    = 3'd2,
        REG_PULSE_TO    = 3'd3,
        REG_SCALE       = 3'd4
    } uer_reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RST   = 20'd200000;
    localparam logic [TRIG_W-1:0]     TRIG_WIDTH_RST = 8'd10;
    localparam logic [CFG_DATA_W-1:0] START_TO_RST   = 20'd30000;
    localparam logic [CFG_DATA_W-1:0] PULSE_TO_RST   = 20'd30000;
    localparam logic [SCALE_W-1:0]    SCALE_RST      = 16'd1124;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] interval_us;
        logic [TRIG_W-1:0]     trigger_width_us;
        logic [CFG_DATA_W-1:0] echo_start_timeout_us;
        logic [CFG_DATA_W-1:0] echo_pulse_timeout_us;
        logic [SCALE_W-1:0]    distance_scale_q16;
    } uer_cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic [DIST_W-1:0] distance_q8;
        logic              distance_valid;
        logic              measurement_done;
    } uer_result_t;

    // Saturating increment
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

[rtl/uer_core.sv]
// Per-tick ranging engine: phase sequencer, tick counters and distance scaling.
module uer_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  logic                 echo_level,
    input  uer_pkg::uer_cfg_t    cfg,
    output uer_pkg::uer_result_t result
);
    import uer_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_RISE = 2'd2,
        PH_TIME = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    phase_ticks_reg, phase_ticks_next;
    logic [CNT_W-1:0]    echo_ticks_reg, echo_ticks_next;
    logic [DIST_W-1:0]   last_dist_reg, last_dist_next;
    logic                last_valid_reg, last_valid_next;

    logic [CNT_W-1:0]    phase_bump;
    logic [CNT_W-1:0]    echo_bump;
    logic [CNT_W-1:0]    trig_limit;
    logic [PROD_W-1:0]   product;
    logic [DIST_W-1:0]   dist_sat;
    logic                trig;
    logic                done;

    assign phase_bump = bump(phase_ticks_reg);
    assign echo_bump  = bump(echo_ticks_reg);
    assign trig_limit = {{(CNT_W-TRIG_W){1'b0}}, cfg.trigger_width_us};

    // Echo high time to cm Q8, truncated and saturated
    assign product  = PROD_W'(echo_ticks_reg) * PROD_W'(cfg.distance_scale_q16);
    assign dist_sat = (|product[PROD_W-1:DIST_W+8]) ? {DIST_W{1'b1}}
                                                    : product[DIST_W+7:8];

    // Phase sequencing for one tick
    always_comb begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_ticks_next  = echo_ticks_reg;
        last_dist_next   = last_dist_reg;
        last_valid_next  = last_valid_reg;
        trig             = 1'b0;
        done             = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                phase_ticks_next = phase_bump;
                if (phase_bump >= cfg.interval_us) begin
                    phase_next       = PH_TRIG;
                    phase_ticks_next = CNT_W'(1);
                    trig             = 1'b1;
                end
            end
            PH_TRIG: begin
                if (phase_ticks_reg >= trig_limit) begin
                    phase_next       = PH_RISE;
                    phase_ticks_next = '0;
                end else begin
                    phase_ticks_next = phase_bump;
                    trig             = 1'b1;
                end
            end
            PH_RISE: begin
                if (echo_level) begin
                    phase_next      = PH_TIME;
                    echo_ticks_next = CNT_W'(1);
                end else begin
                    phase_ticks_next = phase_bump;
                    if (phase_bump >= cfg.echo_start_timeout_us) begin
                        phase_next       = PH_IDLE;
                        phase_ticks_next = '0;
                        last_dist_next   = '0;
                        last_valid_next  = 1'b0;
                        done             = 1'b1;
                    end
                end
            end
            PH_TIME: begin
                if (!echo_level) begin
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                    last_dist_next   = dist_sat;
                    last_valid_next  = 1'b1;
                    done             = 1'b1;
                end else begin
                    echo_ticks_next = echo_bump;
                    if (echo_bump >= cfg.echo_pulse_timeout_us) begin
                        phase_next       = PH_IDLE;
                        phase_ticks_next = '0;
                        last_dist_next   = '0;
                        last_valid_next  = 1'b0;
                        done             = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign result.trigger_level    = trig;
    assign result.distance_q8      = last_valid_next ? last_dist_next : '0;
    assign result.distance_valid   = last_valid_next;
    assign result.measurement_done = done;

    // State advances only on a tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            echo_ticks_reg  <= '0;
            last_dist_reg   <= '0;
            last_valid_reg  <= 1'b0;
        end else if (tick) begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            echo_ticks_reg  <= echo_ticks_next;
            last_dist_reg   <= last_dist_next;
            last_valid_reg  <= last_valid_next;
        end
    end

endmodule

[rtl/ultrasonic_echo_ranger.sv]
// Ultrasonic time-of-flight ranger: one input transaction is one microsecond
// tick carrying the sampled echo level, and each tick returns one result
// transaction with the trigger level, the last distance (cm, Q8), its valid
// flag and a done strobe. A tick passes an input register and then the
// phase logic with one 20x16 multiply into the output register, and one
// tick is taken every cycle as long as the result side keeps up.
// Configuration writes take effect from the cycle after the write and
// should only be made while no tick transaction is in flight.
module ultrasonic_echo_ranger (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // tick input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_echo_level,
    // result output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_trigger_level,
    output logic [uer_pkg::DIST_W-1:0]     m_distance_q8,
    output logic                           m_distance_valid,
    output logic                           m_measurement_done
);
    import uer_pkg::*;

    uer_cfg_t    cfg_reg;
    logic        in_vld_reg;
    logic        echo_reg;
    logic        out_vld_reg;
    uer_result_t out_reg;
    uer_result_t result;
    logic        out_free;
    logic        tick;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval_us           <= INTERVAL_RST;
            cfg_reg.trigger_width_us      <= TRIG_WIDTH_RST;
            cfg_reg.echo_start_timeout_us <= START_TO_RST;
            cfg_reg.echo_pulse_timeout_us <= PULSE_TO_RST;
            cfg_reg.distance_scale_q16    <= SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_INTERVAL:   cfg_reg.interval_us <= cfg_wr_data;
                REG_TRIG_WIDTH: cfg_reg.trigger_width_us <= cfg_wr_data[TRIG_W-1:0];
                REG_START_TO:   cfg_reg.echo_start_timeout_us <= cfg_wr_data;
                REG_PULSE_TO:   cfg_reg.echo_pulse_timeout_us <= cfg_wr_data;
                REG_SCALE:      cfg_reg.distance_scale_q16 <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign out_free = !out_vld_reg || m_ready;
    assign tick     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            echo_reg <= s_echo_level;
        end
    end

    uer_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .echo_level (echo_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_trigger_level    = out_reg.trigger_level;
    assign m_distance_q8      = out_reg.distance_q8;
    assign m_distance_valid   = out_reg.distance_valid;
    assign m_measurement_done = out_reg.measurement_done;

endmodule

[rtl/uer_checker.sv]
// Port-level checker for the ultrasonic echo ranger, with its bind.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_trigger_level,
    input logic [uer_pkg::DIST_W-1:0]     m_distance_q8,
    input logic                           m_distance_valid,
    input logic                           m_measurement_done
);
    import uer_pkg::*;

    // A stalled result transaction holds
    `UER_ASSERT_NEXT(a_out_hold, aclk, aresetn, (m_valid && !m_ready), (m_valid && $stable(m_distance_q8) && $stable(m_distance_valid) && $stable(m_trigger_level) && $stable(m_measurement_done)), "result changed while stalled")

    // No distance without a valid reading
    `UER_ASSERT_NOW(a_dist_zero, aclk, aresetn, (m_valid && !m_distance_valid), (m_distance_q8 == '0), "distance shown without valid reading")

    // The trigger never fires on the tick a measurement ends
    `UER_ASSERT_NOW(a_trig_done, aclk, aresetn, m_valid, (!(m_trigger_level && m_measurement_done)), "trigger and done together")

    // An empty output stage always takes a tick
    `UER_ASSERT_NOW(a_ready_free, aclk, aresetn, (!m_valid), s_ready, "input stalled with empty output")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

[tb/uer_checker.sv]
// Checker for the ultrasonic echo ranger: predicts every tick's result and compares it.
`timescale 1ns / 100ps
module uer_tb_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_echo_level,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_trigger_level,
    input  logic [uer_pkg::DIST_W-1:0]     m_distance_q8,
    input  logic                           m_distance_valid,
    input  logic                           m_measurement_done,
    output int                             error_count,
    output int                             ticks_in_flight
);
    import uer_pkg::*;

    typedef enum logic [1:0] {
        RNG_IDLE,
        RNG_TRIGGER,
        RNG_AWAIT_ECHO,
        RNG_TIMING
    } ranger_phase_t;

    // Shadow settings and measurement state
    uer_cfg_t          settings;
    ranger_phase_t     rng_phase;
    logic [CNT_W-1:0]  phase_ticks;
    logic [CNT_W-1:0]  echo_ticks;
    logic [DIST_W-1:0] last_distance;
    logic              last_valid;

    // Results predicted for accepted ticks, oldest first
    uer_result_t expected_results[$];

    initial begin
        error_count     = 0;
        ticks_in_flight = 0;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] count);
        return (count == {CNT_W{1'b1}}) ? count : count + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [DIST_W-1:0] want,
                                   input logic [DIST_W-1:0] got);
        // keep the log bounded when things go badly wrong
        if (error_count < 40)
            $display("uer_checker: %0t ns: %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // End of a measurement: scale the echo time or mark the reading invalid
    task automatic close_measurement(input logic good, input logic [CNT_W-1:0] duration);
        logic [PROD_W-1:0] product;
        product = PROD_W'(duration) * PROD_W'(settings.distance_scale_q16);
        if (!good) begin
            last_distance = '0;
            last_valid    = 1'b0;
        end else begin
            last_valid = 1'b1;
            if (|product[PROD_W-1:DIST_W+8])
                last_distance = '1;
            else
                last_distance = product[DIST_W+7:8];
        end
        rng_phase   = RNG_IDLE;
        phase_ticks = '0;
    endtask

    // One microsecond tick
    task automatic step_ranger(input logic echo, output uer_result_t res);
        res = '0;
        case (rng_phase)
            RNG_IDLE: begin
                phase_ticks = sat_inc(phase_ticks);
                if (phase_ticks >= settings.interval_us) begin
                    rng_phase         = RNG_TRIGGER;
                    phase_ticks       = CNT_W'(1);
                    res.trigger_level = 1'b1;
                end
            end
            RNG_TRIGGER: begin
                if (phase_ticks >= CNT_W'(settings.trigger_width_us)) begin
                    rng_phase   = RNG_AWAIT_ECHO;
                    phase_ticks = '0;
                end else begin
                    phase_ticks       = sat_inc(phase_ticks);
                    res.trigger_level = 1'b1;
                end
            end
            RNG_AWAIT_ECHO: begin
                // echo is tested before the start timeout
                if (echo) begin
                    rng_phase  = RNG_TIMING;
                    echo_ticks = CNT_W'(1);
                end else begin
                    phase_ticks = sat_inc(phase_ticks);
                    if (phase_ticks >= settings.echo_start_timeout_us) begin
                        close_measurement(1'b0, '0);
                        res.measurement_done = 1'b1;
                    end
                end
            end
            default: begin
                if (!echo) begin
                    close_measurement(1'b1, echo_ticks);
                    res.measurement_done = 1'b1;
                end else begin
                    echo_ticks = sat_inc(echo_ticks);
                    if (echo_ticks >= settings.echo_pulse_timeout_us) begin
                        close_measurement(1'b0, '0);
                        res.measurement_done = 1'b1;
                    end
                end
            end
        endcase
        res.distance_q8    = last_valid ? last_distance : '0;
        res.distance_valid = last_valid;
    endtask

    always @(posedge aclk) begin
        uer_result_t want;
        if (!aresetn) begin
            settings.interval_us           = INTERVAL_RST;
            settings.trigger_width_us      = TRIG_WIDTH_RST;
            settings.echo_start_timeout_us = START_TO_RST;
            settings.echo_pulse_timeout_us = PULSE_TO_RST;
            settings.distance_scale_q16    = SCALE_RST;
            rng_phase     = RNG_IDLE;
            phase_ticks   = '0;
            echo_ticks    = '0;
            last_distance = '0;
            last_valid    = 1'b0;
            expected_results.delete();
            ticks_in_flight = 0;
        end else begin
            // register writes; unknown indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_INTERVAL:   settings.interval_us = cfg_wr_data;
                    REG_TRIG_WIDTH: settings.trigger_width_us = cfg_wr_data[TRIG_W-1:0];
                    REG_START_TO:   settings.echo_start_timeout_us = cfg_wr_data;
                    REG_PULSE_TO:   settings.echo_pulse_timeout_us = cfg_wr_data;
                    REG_SCALE:      settings.distance_scale_q16 = cfg_wr_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, m_distance_q8);
                end else begin
                    want = expected_results.pop_front();
                    if (m_trigger_level !== want.trigger_level)
                        report_mismatch("trigger_level", DIST_W'(want.trigger_level),
                                        DIST_W'(m_trigger_level));
                    if (m_distance_q8 !== want.distance_q8)
                        report_mismatch("distance_q8", want.distance_q8, m_distance_q8);
                    if (m_distance_valid !== want.distance_valid)
                        report_mismatch("distance_valid", DIST_W'(want.distance_valid),
                                        DIST_W'(m_distance_valid));
                    if (m_measurement_done !== want.measurement_done)
                        report_mismatch("measurement_done", DIST_W'(want.measurement_done),
                                        DIST_W'(m_measurement_done));
                end
            end

            // tick transaction: advance the prediction
            if (s_valid && s_ready) begin
                step_ranger(s_echo_level, want);
                expected_results.push_back(want);
            end
            ticks_in_flight = expected_results.size();
        end
    end

endmodule

[tb/tb_ultrasonic_echo_ranger.sv]
// Testbench top for the ultrasonic echo ranger: tick stimulus, settings, idling and verdict.
`timescale 1ns / 100ps
module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_REG     = 3'd7;
    localparam logic [CFG_DATA_W-1:0] COUNT_ALL_ONES   = '1;
    localparam int                    TICKS_PER_ROUND  = 65;
    localparam int                    LONG_HOLD_CYCLES = 80;
    localparam int                    DRAIN_LIMIT      = 20000;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_echo_level = 1'b0;
    logic                  m_ready      = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_trigger_level;
    logic [DIST_W-1:0]     m_distance_q8;
    logic                  m_distance_valid;
    logic                  m_measurement_done;

    int error_count;
    int ticks_in_flight;

    // Stimulus-side copy of the settings, used to shape echo sequences
    int unsigned interval_set = 32'(INTERVAL_RST);
    int unsigned width_set    = 32'(TRIG_WIDTH_RST);
    int unsigned start_to_set = 32'(START_TO_RST);
    int unsigned pulse_to_set = 32'(PULSE_TO_RST);
    int unsigned idle_spent   = 0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit long_hold_req = 1'b0;
    int ticks_sent    = 0;

    ultrasonic_echo_ranger dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_echo_level       (s_echo_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_trigger_level    (m_trigger_level),
        .m_distance_q8      (m_distance_q8),
        .m_distance_valid   (m_distance_valid),
        .m_measurement_done (m_measurement_done)
    );

    uer_tb_checker ranger_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_echo_level       (s_echo_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_trigger_level    (m_trigger_level),
        .m_distance_q8      (m_distance_q8),
        .m_distance_valid   (m_distance_valid),
        .m_measurement_done (m_measurement_done),
        .error_count        (error_count),
        .ticks_in_flight    (ticks_in_flight)
    );

    always #1 aclk = ~aclk;

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_ultrasonic_echo_ranger: done, errors");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // One tick transaction; called and returns at a falling edge
    task automatic send_tick(input logic echo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_echo_level <= echo;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (ticks_in_flight != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
    endtask

    // Rewrite every register once the block is quiet; raw values may carry extra high bits
    task automatic program_ranger(input logic [CFG_DATA_W-1:0] interval,
                                  input logic [CFG_DATA_W-1:0] width,
                                  input logic [CFG_DATA_W-1:0] start_to,
                                  input logic [CFG_DATA_W-1:0] pulse_to,
                                  input logic [CFG_DATA_W-1:0] scale);
        drain_results();
        write_reg(UNMAPPED_REG, CFG_DATA_W'($urandom));
        write_reg(REG_INTERVAL, interval);
        write_reg(REG_TRIG_WIDTH, width);
        write_reg(REG_START_TO, start_to);
        write_reg(REG_PULSE_TO, pulse_to);
        write_reg(REG_SCALE, scale);
        cfg_wr_en    <= 1'b0;
        interval_set = 32'(interval);
        width_set    = 32'(width[TRIG_W-1:0]);
        start_to_set = 32'(start_to);
        pulse_to_set = 32'(pulse_to);
    endtask

    // One measurement: idle and trigger ticks, echo delay, then high time or timeout
    task automatic run_measurement(input int unsigned rise_delay, input int unsigned high_ticks,
                                   input bit noisy);
        int unsigned lead;
        int unsigned start_limit;
        int unsigned pulse_limit;
        lead        = (interval_set > idle_spent) ? interval_set - idle_spent : 1;
        lead        += (width_set == 0) ? 1 : width_set;
        start_limit = (start_to_set == 0) ? 1 : start_to_set;
        // the rising tick is never tested, so the pulse timeout acts from the second high tick
        pulse_limit = (pulse_to_set < 2) ? 2 : pulse_to_set;

        // echo is ignored while idle or triggering
        repeat (lead) send_tick(noisy ? 1'($urandom_range(1)) : 1'b0);
        if (rise_delay >= start_limit) begin
            repeat (start_limit) send_tick(1'b0);
        end else begin
            repeat (rise_delay) send_tick(1'b0);
            if (high_ticks >= pulse_limit) begin
                repeat (pulse_limit) send_tick(1'b1);
            end else begin
                repeat (high_ticks) send_tick(1'b1);
                send_tick(1'b0);
            end
        end
        idle_spent = 0;
    endtask

    task automatic random_measurement();
        int unsigned delay_top;
        int unsigned high_top;
        delay_top = (start_to_set == 0) ? 1 : (start_to_set < 14 ? start_to_set : 14);
        high_top  = (pulse_to_set < 2) ? 2 : (pulse_to_set < 14 ? pulse_to_set : 14);
        run_measurement($urandom_range(delay_top, 0), $urandom_range(high_top, 1),
                        $urandom_range(3) == 0);
    endtask

    // Settings per round: floors, maxima, or random small thresholds
    task automatic choose_settings(input int flavor);
        case (flavor)
            0: program_ranger('0, '0, '0, '0, '0);
            5: program_ranger(CFG_DATA_W'(3), CFG_DATA_W'(255), COUNT_ALL_ONES,
                              COUNT_ALL_ONES, CFG_DATA_W'(16'hFFFF));
            default: program_ranger(CFG_DATA_W'($urandom_range(12)),
                                    {12'($urandom), 8'($urandom_range(8))},
                                    CFG_DATA_W'($urandom_range(12)),
                                    CFG_DATA_W'($urandom_range(12)),
                                    CFG_DATA_W'($urandom));
        endcase
    endtask

    initial begin
        int blk;
        int round;
        int target;
        int wait_cycles;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: idle counting only, echo ignored
        repeat (6) send_tick(1'($urandom_range(1)));
        idle_spent = 6;

        // directed: good echo, start timeout, pulse timeout
        program_ranger(20'd2, 20'd3, 20'd4, 20'd5, CFG_DATA_W'(SCALE_RST));
        run_measurement(1, 3, 1'b0);
        run_measurement(4, 1, 1'b0);
        run_measurement(0, 5, 1'b0);

        // zero thresholds, full scale
        program_ranger('0, '0, '0, '0, CFG_DATA_W'(16'hFFFF));
        run_measurement(0, 1, 1'b0);
        run_measurement(1, 1, 1'b0);
        run_measurement(0, 2, 1'b0);

        // longest interval: no trigger yet, then a short one fires at once
        program_ranger(COUNT_ALL_ONES, 20'd1, 20'd2, 20'd3, '0);
        repeat (5) send_tick(1'b1);
        idle_spent = 5;
        program_ranger(20'd1, 20'hFFF02, 20'd3, 20'd3, CFG_DATA_W'(SCALE_RST));
        run_measurement(0, 2, 1'b1);

        // random measurements under four idling patterns
        for (blk = 0; blk < 4; blk++) begin
            case (blk)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            for (round = 0; round < 4; round++) begin
                choose_settings(blk * 4 + round);
                // block fills while the result side holds off
                if (blk == 0 && round == 2)
                    long_hold_req = 1'b1;
                target = ticks_sent + TICKS_PER_ROUND;
                while (ticks_sent < target)
                    random_measurement();
            end
        end

        // long echo at full scale
        send_idle_pct = 0;
        stall_pct     = 0;
        program_ranger(20'd1, 20'd1, 20'd4, COUNT_ALL_ONES, CFG_DATA_W'(16'hFFFF));
        run_measurement(0, 120, 1'b0);

        // unstructured echo noise
        send_idle_pct = 36;
        stall_pct     = 36;
        program_ranger(20'd1, 20'd1, 20'd3, 20'd3, CFG_DATA_W'($urandom));
        repeat (150) send_tick(1'($urandom_range(1)));

        // wind down
        s_valid   <= 1'b0;
        stall_pct = 0;
        for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && ticks_in_flight != 0;
             wait_cycles++)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (error_count == 0 && ticks_in_flight == 0)
            $display("tb_ultrasonic_echo_ranger: done, clean");
        else
            $display("tb_ultrasonic_echo_ranger: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_core.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
tb/uer_checker.sv
tb/tb_ultrasonic_echo_ranger.sv
